### hw/rtl/sckd_pkg.sv
// ----------------------------------------------------------------------------
// sckd_pkg
// shared types, scan codes, event kinds and key maps of the set-1 key decoder
// ----------------------------------------------------------------------------
`default_nettype none

package sckd_pkg;

    localparam int CHARS_W   = 6;
    localparam int CHARS_MAX = (1 << CHARS_W) - 1;
    localparam int KIND_W    = 4;
    localparam int ASCII_W   = 7;
    localparam int MAP_SIZE  = 58;
    localparam int MAP_IDX_W = 6;
    localparam int LINE_CAPACITY_DEFAULT = 64;

    // event kinds
    localparam logic [KIND_W-1:0] EV_CHAR      = 4'd0;
    localparam logic [KIND_W-1:0] EV_BACKSPACE = 4'd1;
    localparam logic [KIND_W-1:0] EV_ENTER     = 4'd2;
    localparam logic [KIND_W-1:0] EV_HIST_UP   = 4'd3;
    localparam logic [KIND_W-1:0] EV_HIST_DOWN = 4'd4;
    localparam logic [KIND_W-1:0] EV_CUR_UP    = 4'd5;
    localparam logic [KIND_W-1:0] EV_CUR_DOWN  = 4'd6;
    localparam logic [KIND_W-1:0] EV_CUR_LEFT  = 4'd7;
    localparam logic [KIND_W-1:0] EV_CUR_RIGHT = 4'd8;
    localparam logic [KIND_W-1:0] EV_MENU      = 4'd9;

    // scan codes
    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam logic [7:0] SC_LSHIFT    = 8'h2A;
    localparam logic [7:0] SC_RSHIFT    = 8'h36;
    localparam logic [7:0] SC_BACKSPACE = 8'h0E;
    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_LWIN      = 8'h5B;
    localparam logic [7:0] SC_RWIN      = 8'h5C;
    localparam logic [7:0] SC_UP        = 8'h48;
    localparam logic [7:0] SC_DOWN      = 8'h50;
    localparam logic [7:0] SC_LEFT      = 8'h4B;
    localparam logic [7:0] SC_RIGHT     = 8'h4D;

    localparam logic [ASCII_W-1:0] PLAIN_MAP [0:MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h00, 7'h00,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h00, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
        7'h00, 7'h20
    };

    localparam logic [ASCII_W-1:0] UPPER_MAP [0:MAP_SIZE-1] = '{
        7'h00, 7'h00, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h00, 7'h00,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h00, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h00,
        7'h00, 7'h20
    };

    typedef struct packed {
        logic               prefix;
        logic               shift;
        logic [CHARS_W-1:0] chars;
        logic               menu;
    } key_state_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [ASCII_W-1:0] ascii;
        logic [CHARS_W-1:0] len;
        logic               menu;
    } key_event_t;

endpackage

`default_nettype wire

### hw/rtl/sckd_keymap.sv
// ----------------------------------------------------------------------------
// sckd_keymap
// maps a make code to ascii through the plain or shifted table, zero if unmapped
// ----------------------------------------------------------------------------
`default_nettype none

module sckd_keymap
    import sckd_pkg::*;
(
    input  wire logic [7:0]         scan_code,
    input  wire logic               shift,
    output logic      [ASCII_W-1:0] ascii
);

    logic [MAP_IDX_W-1:0] idx;

    assign idx = scan_code[MAP_IDX_W-1:0];

    always_comb begin
        if (scan_code >= 8'(MAP_SIZE)) begin
            ascii = '0;
        end else if (shift) begin
            ascii = UPPER_MAP[idx];
        end else begin
            ascii = PLAIN_MAP[idx];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sckd_event_logic.sv
// ----------------------------------------------------------------------------
// sckd_event_logic
// decodes one byte against the key state: next state and optional event
// ----------------------------------------------------------------------------
`default_nettype none

module sckd_event_logic
    import sckd_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
    input  wire logic       scan_byte,
    input  wire logic [7:0] scan_code,
    input  wire key_state_t cur,
    output key_state_t      nxt,
    output logic            hit,
    output key_event_t      ev
);

    localparam int LIMIT_RAW = LINE_CAPACITY - 1;
    localparam logic [CHARS_W-1:0] LINE_LIMIT =
        (LIMIT_RAW > CHARS_MAX) ? CHARS_W'(CHARS_MAX) : CHARS_W'(LIMIT_RAW);

    logic [ASCII_W-1:0] code;

    sckd_keymap u_keymap (
        .scan_code (scan_code),
        .shift     (cur.shift),
        .ascii     (code)
    );

    // scan_byte is low for bytes from the aux port
    always_comb begin
        nxt      = cur;
        hit      = 1'b0;
        ev.kind  = EV_CHAR;
        ev.ascii = '0;
        ev.len   = cur.chars;
        if (!scan_byte) begin
            hit = 1'b0;
        end else if (scan_code == SC_PREFIX) begin
            nxt.prefix = 1'b1;
        end else if (cur.prefix) begin
            nxt.prefix = 1'b0;
            if (scan_code[7]) begin
                hit = 1'b0;
            end else if (scan_code == SC_LWIN || scan_code == SC_RWIN) begin
                nxt.menu = ~cur.menu;
                hit      = 1'b1;
                ev.kind  = EV_MENU;
            end else if (cur.shift) begin
                if (scan_code == SC_UP) begin
                    hit     = 1'b1;
                    ev.kind = EV_HIST_UP;
                end else if (scan_code == SC_DOWN) begin
                    hit     = 1'b1;
                    ev.kind = EV_HIST_DOWN;
                end
            end else if (scan_code == SC_UP) begin
                hit     = 1'b1;
                ev.kind = EV_CUR_UP;
            end else if (scan_code == SC_DOWN) begin
                hit     = 1'b1;
                ev.kind = EV_CUR_DOWN;
            end else if (scan_code == SC_LEFT) begin
                hit     = 1'b1;
                ev.kind = EV_CUR_LEFT;
            end else if (scan_code == SC_RIGHT) begin
                hit     = 1'b1;
                ev.kind = EV_CUR_RIGHT;
            end
        end else if (scan_code[7]) begin
            if ({1'b0, scan_code[6:0]} == SC_LSHIFT || {1'b0, scan_code[6:0]} == SC_RSHIFT) begin
                nxt.shift = 1'b0;
            end
        end else if (scan_code == SC_LSHIFT || scan_code == SC_RSHIFT) begin
            nxt.shift = 1'b1;
        end else if (scan_code == SC_BACKSPACE) begin
            if (cur.chars != '0) begin
                nxt.chars = cur.chars - 1'b1;
                hit       = 1'b1;
                ev.kind   = EV_BACKSPACE;
                ev.len    = cur.chars - 1'b1;
            end
        end else if (scan_code == SC_ENTER) begin
            nxt.chars = '0;
            hit       = 1'b1;
            ev.kind   = EV_ENTER;
        end else if (code != '0 && cur.chars < LINE_LIMIT) begin
            nxt.chars = cur.chars + 1'b1;
            hit       = 1'b1;
            ev.ascii  = code;
            ev.len    = cur.chars + 1'b1;
        end
        ev.menu = nxt.menu;
    end

endmodule

`default_nettype wire

### hw/rtl/scancode_set1_key_event_decoder.sv
// ----------------------------------------------------------------------------
// scancode_set1_key_event_decoder
// set-1 keyboard byte stream to key events (characters, edit keys, arrows, menu)
// ----------------------------------------------------------------------------
// One byte can be accepted per clock unless the output stalls. Its event, if any,
// follows the byte through an input register and a single pass of decode logic
// that updates the key state and loads the output register.
// Throughput is one item per cycle while m_axis_tready is high; a held output
// item stalls the input once the input register is also full. Bytes that
// cause no event produce no output item.
`default_nettype none

module scancode_set1_key_event_decoder
    import sckd_pkg::*;
#(
    parameter int LINE_CAPACITY = LINE_CAPACITY_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] scan_byte
    input  wire logic        s_axis_tuser,   // [0] from_aux

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [6:0] ascii_code, [12:7] line_length,
                                             // [13] menu_is_open, [15:14] zero
    output logic [3:0]       m_axis_tuser    // [3:0] event_kind
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_aux_reg;

    key_state_t state_reg;
    key_state_t state_next;

    logic       out_valid_reg;
    key_event_t out_item_reg;

    logic       hit;
    key_event_t ev;
    logic       advance;

    sckd_event_logic #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_event_logic (
        .scan_byte (~in_aux_reg),
        .scan_code (in_byte_reg),
        .cur       (state_reg),
        .nxt       (state_next),
        .hit       (hit),
        .ev        (ev)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_byte_reg <= s_axis_tdata;
            in_aux_reg  <= s_axis_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            state_reg     <= state_next;
            out_valid_reg <= hit;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && hit) begin
            out_item_reg <= ev;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_item_reg.kind;
    assign m_axis_tdata  = {2'b00, out_item_reg.menu, out_item_reg.len, out_item_reg.ascii};

endmodule

`default_nettype wire
